### rtl/optical_sample_unpack_ring_defines.svh
// Assertion macros shared by the optical sample unpack ring checkers.
`ifndef OPTICAL_SAMPLE_UNPACK_RING_DEFINES_SVH
`define OPTICAL_SAMPLE_UNPACK_RING_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define OSUR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define OSUR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/osur_pkg.sv
// Shared types and constants of the optical sample unpack ring.
`timescale 1ns / 1ps
package osur_pkg;

	localparam int BYTE_W          = 8;
	localparam int SAMPLE_W        = 18;
	localparam int ACC_W           = SAMPLE_W - BYTE_W;
	localparam int PHASE_W         = 3;
	localparam int CNT_W           = 5;
	localparam int SUM_W           = 10;
	localparam int OUT_W           = 80;
	localparam int DEF_RING_DEPTH  = 32;

	localparam logic ACT_PUSH      = 1'b0;
	localparam logic ACT_ADVANCE   = 1'b1;
	localparam logic TWO_LEDS_RST  = 1'b1;

	localparam logic [PHASE_W-1:0] PHASE_RED_DONE  = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_PAIR_DONE = 3'd6;

	// Ring write request from the deframer.
	typedef struct packed {
		logic                store;
		logic                write_ir;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] ir;
	} osur_wr_t;

	// Registered read data: port a at the head, port b at the tail.
	typedef struct packed {
		logic [SAMPLE_W-1:0] red_a;
		logic [SAMPLE_W-1:0] ir_a;
		logic [SAMPLE_W-1:0] red_b;
		logic [SAMPLE_W-1:0] ir_b;
	} osur_rd_t;

endpackage

### rtl/osur_deframe.sv
// Byte framer: assembles big-endian 18-bit red and infrared samples.
`timescale 1ns / 1ps
module osur_deframe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [osur_pkg::BYTE_W-1:0]  data_byte,
	input  logic                         two_leds,
	input  logic                         restart,
	output osur_pkg::osur_wr_t           wr
);
	import osur_pkg::*;

	logic [PHASE_W-1:0]  phase_q, phase_d, phase_inc;
	logic [ACC_W-1:0]    acc_q, acc_d;
	logic [SAMPLE_W-1:0] hold_q, hold_d;
	logic [SAMPLE_W-1:0] acc_next;

	always_comb begin
		acc_next  = {acc_q, data_byte};
		phase_inc = phase_q + 1'b1;
		phase_d   = phase_q;
		acc_d     = acc_q;
		hold_d    = hold_q;
		wr        = '0;
		if (push) begin
			acc_d   = acc_next[ACC_W-1:0];
			phase_d = phase_inc;
			if (two_leds) begin
				if (phase_inc == PHASE_RED_DONE) begin
					hold_d = acc_next;
				end else if (phase_inc >= PHASE_PAIR_DONE) begin
					wr.store    = 1'b1;
					wr.write_ir = 1'b1;
					wr.red      = hold_q;
					wr.ir       = acc_next;
					phase_d     = '0;
				end
			end else if (phase_inc >= PHASE_RED_DONE) begin
				wr.store = 1'b1;
				wr.red   = acc_next;
				phase_d  = '0;
			end
		end
		// drop partial bytes on a mode write
		if (restart) begin
			phase_d = '0;
			acc_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			acc_q   <= '0;
			hold_q  <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			hold_q  <= hold_d;
		end
	end

endmodule

### rtl/osur_ring.sv
// Sample ring storage: red and infrared memories, one write and two read ports.
`timescale 1ns / 1ps
module osur_ring #(
	parameter int RING_DEPTH = osur_pkg::DEF_RING_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  osur_pkg::osur_wr_t            wr,
	input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
	input  logic                          rd_en,
	input  logic [$clog2(RING_DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(RING_DEPTH)-1:0] rd_addr_b,
	output osur_pkg::osur_rd_t            rd
);
	import osur_pkg::*;

	logic [SAMPLE_W-1:0]   red_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0]   ir_mem  [RING_DEPTH];
	logic [RING_DEPTH-1:0] red_vld_q;
	logic [RING_DEPTH-1:0] ir_vld_q;

	always_ff @(posedge clk) begin
		if (wr.store) begin
			red_mem[wr_addr] <= wr.red;
		end
		if (wr.store && wr.write_ir) begin
			ir_mem[wr_addr] <= wr.ir;
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld_q <= '0;
			ir_vld_q  <= '0;
		end else begin
			if (wr.store) begin
				red_vld_q[wr_addr] <= 1'b1;
			end
			if (wr.store && wr.write_ir) begin
				ir_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd.red_a <= red_vld_q[rd_addr_a] ? red_mem[rd_addr_a] : '0;
			rd.ir_a  <= ir_vld_q[rd_addr_a]  ? ir_mem[rd_addr_a]  : '0;
			rd.red_b <= red_vld_q[rd_addr_b] ? red_mem[rd_addr_b] : '0;
			rd.ir_b  <= ir_vld_q[rd_addr_b]  ? ir_mem[rd_addr_b]  : '0;
		end
	end

endmodule

### rtl/optical_sample_unpack_ring.sv
// Top level of the optical sample unpack ring: sequencer, ring pointers, result register.
`timescale 1ns / 1ps
// Sensor FIFO bytes enter one per transaction on the slave stream; tuser selects a
// byte push (0) or a tail advance (1). Three bytes form a big-endian 24-bit word
// whose low 18 bits are one sample, red first and then infrared when two_leds is
// set. Each complete sample (or pair) moves the head one slot, wrapping with no
// overrun check, and is written at the new head. Every input transaction yields
// exactly one result transaction with the newest and oldest red and infrared
// values, the count (head - tail) mod RING_DEPTH in five bits, and a flag for a
// stored sample. An item passes through accept and write, synchronous memory
// read and the load of the result register, in that order, and the next input
// is taken only when the block is idle again after that load. A new item is
// taken while a result still waits in the output register; only its load stalls
// until that result has left. The ring reads as all zero after reset through
// per-entry valid bits, so no clearing pass is needed. Write two_leds only
// while the block is idle; any write restarts the byte framing.
module optical_sample_unpack_ring #(
	parameter int RING_DEPTH = osur_pkg::DEF_RING_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [osur_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]                   s_tuser,   // [0] action
	// master stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [17:0] newest_red, [35:18] newest_ir, [53:36] oldest_red,
	// [71:54] oldest_ir, [76:72] available, [77] sample_stored, [79:78] zero
	output logic [osur_pkg::OUT_W-1:0]   m_tdata,
	// mode register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_data   // [0] two_leds
);
	import osur_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t             state_q;
	logic               two_leds_q;
	logic [IDX_W-1:0]   head_q, tail_q, head_inc, tail_inc;
	logic               stored_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_q;
	logic               s_accept, cfg_accept, push, advance, load;
	logic [SUM_W-1:0]   diff, count;
	osur_wr_t           wr;
	osur_rd_t           rd;

	// Take input only when idle; a pending mode write goes first.
	assign s_tready   = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready  = (state_q == ST_IDLE);
	assign s_accept   = s_tvalid && s_tready;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign push       = s_accept && (s_tuser[0] == ACT_PUSH);
	assign advance    = s_accept && (s_tuser[0] == ACT_ADVANCE);

	assign head_inc = (head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	osur_deframe u_deframe (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (s_tdata),
		.two_leds  (two_leds_q),
		.restart   (cfg_accept),
		.wr        (wr)
	);

	// Write lands at the accept edge; the read of head and tail follows in the next cycle, in ST_READ.
	osur_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.wr_addr   (head_inc),
		.rd_en     (state_q == ST_READ),
		.rd_addr_a (head_q),
		.rd_addr_b (tail_q),
		.rd        (rd)
	);

	// Available count: head minus tail, wrapped into the ring depth.
	always_comb begin
		diff  = SUM_W'(head_q) + SUM_W'(RING_DEPTH) - SUM_W'(tail_q);
		count = (diff >= SUM_W'(RING_DEPTH)) ? diff - SUM_W'(RING_DEPTH) : diff;
	end

	// Load the result once the previous one has left.
	assign load = (state_q == ST_LOAD) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			two_leds_q <= TWO_LEDS_RST;
			head_q     <= '0;
			tail_q     <= '0;
			stored_q   <= 1'b0;
		end else begin
			if (cfg_accept) begin
				two_leds_q <= cfg_data[0];
			end
			if (wr.store) begin
				head_q <= head_inc;
			end
			// advance the tail only while samples are waiting
			if (advance && (head_q != tail_q)) begin
				tail_q <= tail_inc;
			end
			if (s_accept) begin
				stored_q <= wr.store;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= {2'b00, stored_q, count[CNT_W-1:0],
				rd.ir_b, rd.red_b, rd.ir_a, rd.red_a};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### rtl/osur_checker.sv
// Port-level checker for the optical sample unpack ring, bound to the top level.
`timescale 1ns / 1ps
`include "optical_sample_unpack_ring_defines.svh"
module osur_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [osur_pkg::OUT_W-1:0] m_tdata,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready
);
	// Hold a stalled result.
	`OSUR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "result changed while stalled")
	// An input transaction blocks further input for the read and load cycles.
	`OSUR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready,
		!s_tready ##1 !s_tready, "input taken while item in flight")
	// A mode write and an input transaction never share an edge.
	`OSUR_ASSERT_NOW(a_cfg_excl, cfg_valid && cfg_ready,
		!(s_tvalid && s_tready), "mode write collided with input")
endmodule

bind optical_sample_unpack_ring osur_checker u_osur_checker (.*);

### tb/tb_optical_sample_unpack_ring.sv
// Self-checking testbench for the optical sample unpack ring.
`timescale 1ns / 1ps
// Drive sensor FIFO bytes and tail advances into the slave stream. A scoreboard
// keeps its own copy of the deframer, the ring and both pointers, and predicts the
// ring view that each input transaction must produce. Compare every result
// transaction field by field with the oldest prediction. Mode writes go in only
// while the ring is idle, and the run covers both LED modes, overrun of the ring,
// empty advances, advances in the middle of a sample and framing restarts.
module tb_optical_sample_unpack_ring;

	import osur_pkg::*;

	localparam int DEPTH = DEF_RING_DEPTH;
	// Allow a margin after the last result before any mode write.
	localparam int SETTLE_CYCLES = 8;
	// Time limit for the whole run, with a wide margin over the slowest correct run.
	localparam longint LIMIT_NS = 3_000_000;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 205;

	// One result transaction, highest bits first so that it overlays m_tdata.
	typedef struct packed {
		logic [1:0]          pad;
		logic                sample_stored;
		logic [CNT_W-1:0]    available;
		logic [SAMPLE_W-1:0] oldest_ir;
		logic [SAMPLE_W-1:0] oldest_red;
		logic [SAMPLE_W-1:0] newest_ir;
		logic [SAMPLE_W-1:0] newest_red;
	} ring_view_t;

	// Shadow of the deframer and the ring, plus the queue of predicted views.
	class ring_scoreboard;
		logic [SAMPLE_W-1:0] red_ring [DEPTH];
		logic [SAMPLE_W-1:0] ir_ring [DEPTH];
		int                  head;
		int                  tail;
		int                  phase;
		logic [23:0]         acc;
		logic [SAMPLE_W-1:0] red_hold;
		logic                two_leds;
		ring_view_t          pending_views[$];
		int                  failures;
		int                  items;
		int                  samples;
		int                  advances;
		int                  empty_advances;
		int                  overruns;
		int                  max_count;

		function new();
			foreach (red_ring[i]) begin
				red_ring[i] = '0;
				ir_ring[i] = '0;
			end
			head = 0;
			tail = 0;
			phase = 0;
			acc = '0;
			red_hold = '0;
			two_leds = TWO_LEDS_RST;
			failures = 0;
			items = 0;
			samples = 0;
			advances = 0;
			empty_advances = 0;
			overruns = 0;
			max_count = 0;
		endfunction

		function int count();
			return (head + DEPTH - tail) % DEPTH;
		endfunction

		function int pending();
			return pending_views.size();
		endfunction

		// Any write, even of the same value, drops the bytes gathered so far.
		function void set_mode(logic v);
			two_leds = v;
			phase = 0;
			acc = '0;
		endfunction

		// Advance the head and write the new slot; red-only keeps the old infrared.
		function void store_sample(logic [SAMPLE_W-1:0] red, logic [SAMPLE_W-1:0] ir,
				logic write_ir);
			head = (head + 1) % DEPTH;
			if (head == tail)
				overruns++;
			red_ring[head] = red;
			if (write_ir)
				ir_ring[head] = ir;
			phase = 0;
			samples++;
		endfunction

		// Apply one accepted input transaction and queue the view it must produce.
		function void note_item(logic act, logic [BYTE_W-1:0] b);
			ring_view_t v;
			logic       stored;
			stored = 1'b0;
			items++;
			if (act == ACT_ADVANCE) begin
				advances++;
				if (count() != 0)
					tail = (tail + 1) % DEPTH;
				else
					empty_advances++;
			end else begin
				acc = {acc[15:0], b};
				phase++;
				if (two_leds) begin
					if (phase == int'(PHASE_RED_DONE)) begin
						red_hold = acc[SAMPLE_W-1:0];
					end else if (phase >= int'(PHASE_PAIR_DONE)) begin
						store_sample(red_hold, acc[SAMPLE_W-1:0], 1'b1);
						stored = 1'b1;
					end
				end else if (phase >= int'(PHASE_RED_DONE)) begin
					store_sample(acc[SAMPLE_W-1:0], '0, 1'b0);
					stored = 1'b1;
				end
			end
			if (count() > max_count)
				max_count = count();
			v.pad = '0;
			v.sample_stored = stored;
			v.available = CNT_W'(count());
			v.newest_red = red_ring[head];
			v.newest_ir = ir_ring[head];
			v.oldest_red = red_ring[tail];
			v.oldest_ir = ir_ring[tail];
			pending_views.push_back(v);
		endfunction

		// Compare one accepted result transaction with the oldest prediction.
		function void check_view(logic [OUT_W-1:0] raw);
			ring_view_t got;
			ring_view_t want;
			string      bad;
			got = raw;
			if (pending_views.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with nothing pending: %h", $time, raw);
				return;
			end
			want = pending_views.pop_front();
			bad = "";
			if (got.newest_red !== want.newest_red) bad = {bad, " newest_red"};
			if (got.newest_ir !== want.newest_ir) bad = {bad, " newest_ir"};
			if (got.oldest_red !== want.oldest_red) bad = {bad, " oldest_red"};
			if (got.oldest_ir !== want.oldest_ir) bad = {bad, " oldest_ir"};
			if (got.available !== want.available) bad = {bad, " available"};
			if (got.sample_stored !== want.sample_stored) bad = {bad, " sample_stored"};
			if (bad != "") begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: mismatch in%s", $time, bad);
					$display("  exp nr=%h ni=%h or=%h oi=%h cnt=%0d st=%b", want.newest_red,
						want.newest_ir, want.oldest_red, want.oldest_ir, want.available,
						want.sample_stored);
					$display("  got nr=%h ni=%h or=%h oi=%h cnt=%0d st=%b", got.newest_red,
						got.newest_ir, got.oldest_red, got.oldest_ir, got.available,
						got.sample_stored);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic [0:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [0:0]       cfg_data;

	ring_scoreboard sb;
	int burst_left;
	int tx_gap_max;
	int rx_mode;
	int rx_tick = 0;
	int rx_stall = 0;
	int mode_writes;

	optical_sample_unpack_ring u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: each mode stalls on its own pattern; mode 0 never stalls.
	always @(negedge clk) begin
		rx_tick++;
		case (rx_mode)
			1: begin
				m_tready = ($urandom_range(0, 3) != 0);
			end
			2: begin
				m_tready = ((rx_tick % 7) < 4);
			end
			3: begin
				if (rx_stall > 0) begin
					rx_stall--;
					m_tready = 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					rx_stall = $urandom_range(4, 15);
					m_tready = 1'b0;
				end else begin
					m_tready = 1'b1;
				end
			end
			default: begin
				m_tready = 1'b1;
			end
		endcase
	end

	// Sample every handshake at the rising edge; note inputs before checking results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready)
				sb.check_view(m_tdata);
			if (cfg_valid && cfg_ready)
				sb.set_mode(cfg_data[0]);
		end
	end

	// Send one transaction, opening a new burst after a random gap when one ends.
	task automatic push_item(input logic act, input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Drop valid and wait until every predicted view has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write two_leds only once the ring is idle.
	task automatic write_mode(input logic v);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		mode_writes++;
	endtask

	task automatic push_bytes(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
			input logic [BYTE_W-1:0] b2);
		push_item(ACT_PUSH, b0);
		push_item(ACT_PUSH, b1);
		push_item(ACT_PUSH, b2);
	endtask

	// End the run if it hangs.
	initial begin
		#(LIMIT_NS);
		$display("%0t: timeout with %0d results pending", $time, sb.pending());
		$display("[optical_sample_unpack_ring] ERROR");
		$finish;
	end

	initial begin
		int modes [N_PHASES];
		int adv_pct [N_PHASES];
		int gaps [N_PHASES];
		logic act;
		modes = '{1, 0, 1, 0, 0, 1, 1, 0};
		adv_pct = '{25, 3, 10, 40, 2, 5, 50, 15};
		gaps = '{0, 3, 8, 1, 0, 5, 2, 12};
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		rx_mode = 0;
		burst_left = 0;
		tx_gap_max = 0;
		mode_writes = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, two LEDs from reset. Advance on an empty ring first.
		push_item(ACT_ADVANCE, 8'hff);
		// Full-scale red with all word bits set, zero infrared.
		push_bytes(8'hff, 8'hff, 8'hff);
		push_bytes(8'h00, 8'h00, 8'h00);
		// Advance the tail in the middle of a pair; the framing must carry on.
		push_item(ACT_PUSH, 8'h01);
		push_item(ACT_PUSH, 8'h02);
		push_item(ACT_ADVANCE, 8'h5a);
		push_bytes(8'h03, 8'h80, 8'h00);
		push_item(ACT_PUSH, 8'h7f);
		// Leave two bytes gathered, then switch to red only; they are dropped.
		push_item(ACT_PUSH, 8'hab);
		push_item(ACT_PUSH, 8'hcd);
		write_mode(1'b0);
		// Red-only store keeps the old infrared value at the slot.
		push_bytes(8'h12, 8'h34, 8'h56);
		// Rewrite the same mode mid-sample; the gathered byte is dropped again.
		push_item(ACT_PUSH, 8'hee);
		write_mode(1'b0);
		push_bytes(8'h00, 8'h00, 8'h01);

		// Random part: each phase sets the mode, advance rate and idling of both sides.
		for (int p = 0; p < N_PHASES; p++) begin
			write_mode(modes[p][0]);
			rx_mode = p % 4;
			tx_gap_max = gaps[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Hold off once until the ring has fully answered.
				if (p == 3 && i == PHASE_ITEMS / 2)
					drain();
				act = ($urandom_range(0, 99) < adv_pct[p]) ? ACT_ADVANCE : ACT_PUSH;
				push_item(act, BYTE_W'($urandom_range(0, 255)));
			end
		end

		drain();
		$display("Ran %0d items in %0d mode writes: %0d samples stored, %0d overruns,",
			sb.items, mode_writes, sb.samples, sb.overruns);
		$display("%0d tail advances (%0d on an empty ring), peak count %0d.",
			sb.advances, sb.empty_advances, sb.max_count);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("[optical_sample_unpack_ring] OK");
		end else begin
			$display("%0d failures, %0d results missing", sb.failures, sb.pending());
			$display("[optical_sample_unpack_ring] ERROR");
		end
		$finish;
	end

endmodule
